FILE: hw/rtl/swqt_pkg.sv
// Shared types and codes for the semaphore wait queue table.
// Used by swqt_cell and semaphore_wait_queue_table_top; no dependencies.
package swqt_pkg;

   // Widest descriptor/process index the block supports (256 entries).
   localparam int IDX_W_MAX = 8;

   typedef logic [IDX_W_MAX-1:0] idx_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_OUT    = 2'd2,
      CMD_HEAD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_PREP = 2'd1,
      S_SCAN = 2'd2,
      S_EXEC = 2'd3
   } fsm_type;

   // Search terms broadcast to every cell during a scan.
   typedef struct packed {
      logic [31:0] key;
      logic        pred_en;
      idx_type     victim;
      idx_type     vdesc;
   } query_type;

   // What the cell holding the scan token reports; all zero elsewhere.
   typedef struct packed {
      logic    match;
      logic    free;
      logic    pred;
      logic    valid;
      idx_type head;
      idx_type tail;
   } probe_type;

   // One addressed write into a per-cell field.
   typedef struct packed {
      logic    en;
      idx_type idx;
      idx_type val;
   } wport_type;

   // Update broadcast to the cells when execute fires; later ports win.
   typedef struct packed {
      logic        alloc_en;
      idx_type     alloc_idx;
      logic [31:0] alloc_key;
      logic        rel_en;
      idx_type     rel_idx;
      wport_type   head1;
      wport_type   head2;
      wport_type   tail1;
      wport_type   tail2;
      wport_type   next1;
      wport_type   next2;
      wport_type   next3;
      logic        blk_clr_en;
      idx_type     blk_clr_idx;
      wport_type   blk_set;
   } write_type;

endpackage

FILE: hw/rtl/semaphore_wait_queue_table_top.sv
// Flow: a request beat passes one setup state, a token scan of one cell per
//   cycle and one execute state, which waits for a free response register.
// A new command is taken only in idle, after the last one has executed.
// Reset: synchronous; descriptor valid marks and process blocked marks
//   clear at once, so the table is usable in the first cycle after reset.
module semaphore_wait_queue_table_top #(
   parameter int NUM_PROCS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request: [1:0] command, [33:2] sem_key, [38:34] proc_id, [39] zero
   input  logic [39:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // response: [1:0] status, [6:2] result_proc, [7] zero
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);
   import swqt_pkg::*;

   localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam logic [8:0]    NP9  = 9'(NUM_PROCS);
   localparam logic [IW-1:0] LAST = IW'(NUM_PROCS - 1);

   fsm_type       state_ff, state_in;
   cmd_type       cmd_ff;
   logic [31:0]   key_ff;
   logic [4:0]    proc_ff;
   logic          blk_ff;
   logic [IW-1:0] vdesc_ff;
   logic [IW-1:0] scan_cnt_ff;

   // scan captures
   logic          mfound_ff, ffound_ff, pfound_ff;
   logic [IW-1:0] midx_ff, mhead_ff, mtail_ff, fidx_ff, pidx_ff;
   logic          ovalid_ff;
   logic [IW-1:0] ohead_ff, otail_ff;

   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   logic [4:0]    rsp_proc_ff;

   logic          token_chain [NUM_PROCS+1];
   probe_type     probe_arr   [NUM_PROCS];
   idx_type       next_arr    [NUM_PROCS];
   logic          blk_arr     [NUM_PROCS];
   idx_type       desc_arr    [NUM_PROCS];
   probe_type     probe_or;
   query_type     query;
   write_type     wr;

   logic          p_ok;
   logic [IW-1:0] p_idx;
   logic          go;
   status_type    status_c;
   logic [4:0]    rp_c;

   assign p_ok  = ({4'b0, proc_ff} < NP9);
   assign p_idx = IW'(proc_ff);

   // ---------------- row of cells ----------------
   assign token_chain[0] = (state_ff == S_PREP);

   for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
      swqt_cell #(
         .NUM_PROCS (NUM_PROCS),
         .INDEX     (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .token_in    (token_chain[i]),
         .token_out   (token_chain[i+1]),
         .query       (query),
         .wr          (wr),
         .probe       (probe_arr[i]),
         .next_out    (next_arr[i]),
         .blocked_out (blk_arr[i]),
         .desc_out    (desc_arr[i])
      );
   end

   // Only the token holder drives a nonzero probe.
   always_comb begin
      probe_or = '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
         probe_or = probe_type'(probe_or | probe_arr[i]);
      end
   end

   always_comb begin
      query         = '0;
      query.key     = key_ff;
      query.pred_en = blk_ff && p_ok && (cmd_ff == CMD_INSERT || cmd_ff == CMD_OUT);
      query.victim  = IDX_W_MAX'(p_idx);
      query.vdesc   = IDX_W_MAX'(vdesc_ff);
   end

   // ---------------- sequencer ----------------
   assign go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = S_PREP;
         end
         S_PREP: state_in = S_SCAN;
         S_SCAN: begin
            if (scan_cnt_ff == LAST) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (go) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Latch the command, look up the process, then sweep the token.
   always_ff @(posedge clock) begin
      if (reset) begin
         mfound_ff <= 1'b0;
         ffound_ff <= 1'b0;
         pfound_ff <= 1'b0;
      end else if (state_ff == S_PREP) begin
         mfound_ff <= 1'b0;
         ffound_ff <= 1'b0;
         pfound_ff <= 1'b0;
      end else if (state_ff == S_SCAN) begin
         if (probe_or.match) mfound_ff <= 1'b1;
         if (probe_or.free)  ffound_ff <= 1'b1;
         if (probe_or.pred)  pfound_ff <= 1'b1;
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         cmd_ff  <= cmd_type'(req_tdata[1:0]);
         key_ff  <= req_tdata[33:2];
         proc_ff <= req_tdata[38:34];
      end
      if (state_ff == S_PREP) begin
         blk_ff      <= p_ok && blk_arr[p_idx];
         vdesc_ff    <= IW'(desc_arr[p_idx]);
         scan_cnt_ff <= '0;
      end
      if (state_ff == S_SCAN) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
         if (probe_or.match && !mfound_ff) begin
            midx_ff  <= scan_cnt_ff;
            mhead_ff <= IW'(probe_or.head);
            mtail_ff <= IW'(probe_or.tail);
         end
         if (probe_or.free && !ffound_ff) fidx_ff <= scan_cnt_ff;
         if (probe_or.pred) pidx_ff <= scan_cnt_ff;
         if (scan_cnt_ff == vdesc_ff) begin
            ovalid_ff <= probe_or.valid;
            ohead_ff  <= IW'(probe_or.head);
            otail_ff  <= IW'(probe_or.tail);
         end
      end
   end

   // ---------------- execute ----------------
   always_comb begin
      logic          is_ins, is_rem, do_ins, alloc, det;
      logic          at_head, is_tail, empty, tgt_empty, move_tail;
      logic [IW-1:0] d, v, vd, hd, tl, nxt, tt;

      is_ins    = (cmd_ff == CMD_INSERT);
      is_rem    = (cmd_ff == CMD_REMOVE);
      do_ins    = is_ins && p_ok && (mfound_ff || ffound_ff);
      alloc     = do_ins && !mfound_ff;
      d         = mfound_ff ? midx_ff : fidx_ff;
      status_c  = STAT_MISS;
      rp_c      = '0;
      det       = 1'b0;
      v         = p_idx;
      vd        = vdesc_ff;
      hd        = ohead_ff;
      tl        = otail_ff;

      case (cmd_ff)
         CMD_INSERT: begin
            if (do_ins) status_c = STAT_OK;
            else if (p_ok) status_c = STAT_FULL;
            det = do_ins && blk_ff && ovalid_ff;
         end
         CMD_REMOVE, CMD_HEAD: begin
            if (mfound_ff) begin
               status_c = STAT_OK;
               rp_c     = 5'(mhead_ff);
            end
            det = is_rem && mfound_ff;
            v   = mhead_ff;
            vd  = midx_ff;
            hd  = mhead_ff;
            tl  = mtail_ff;
         end
         CMD_OUT: begin
            if (p_ok && blk_ff) begin
               status_c = STAT_OK;
               rp_c     = proc_ff;
            end
            det = p_ok && blk_ff && ovalid_ff;
         end
         default: status_c = STAT_MISS;
      endcase

      nxt       = IW'(next_arr[v]);
      at_head   = (hd == v);
      is_tail   = (tl == v);
      empty     = det && at_head && is_tail;
      move_tail = det && !at_head && pfound_ff && is_tail;
      tgt_empty = alloc || (empty && vd == d);
      tt        = (move_tail && vd == d) ? pidx_ff : mtail_ff;

      wr             = '0;
      wr.alloc_en    = go && alloc;
      wr.alloc_idx   = IDX_W_MAX'(d);
      wr.alloc_key   = key_ff;
      wr.rel_en      = go && empty && !(is_ins && vd == d);
      wr.rel_idx     = IDX_W_MAX'(vd);
      // unlink the victim from its queue
      wr.head1.en    = go && det && at_head && !is_tail;
      wr.head1.idx   = IDX_W_MAX'(vd);
      wr.head1.val   = IDX_W_MAX'(nxt);
      wr.next1.en    = go && det && !at_head && pfound_ff;
      wr.next1.idx   = IDX_W_MAX'(pidx_ff);
      wr.next1.val   = IDX_W_MAX'(nxt);
      wr.tail1.en    = go && move_tail;
      wr.tail1.idx   = IDX_W_MAX'(vd);
      wr.tail1.val   = IDX_W_MAX'(pidx_ff);
      wr.blk_clr_en  = go && (det || (cmd_ff == CMD_OUT && p_ok && blk_ff));
      wr.blk_clr_idx = IDX_W_MAX'(v);
      // append the process at the tail of the target queue
      wr.head2.en    = go && do_ins && tgt_empty;
      wr.head2.idx   = IDX_W_MAX'(d);
      wr.head2.val   = IDX_W_MAX'(p_idx);
      wr.next2.en    = go && do_ins && !tgt_empty;
      wr.next2.idx   = IDX_W_MAX'(tt);
      wr.next2.val   = IDX_W_MAX'(p_idx);
      wr.tail2.en    = go && do_ins;
      wr.tail2.idx   = IDX_W_MAX'(d);
      wr.tail2.val   = IDX_W_MAX'(p_idx);
      wr.next3.en    = go && do_ins;
      wr.next3.idx   = IDX_W_MAX'(p_idx);
      wr.next3.val   = IDX_W_MAX'(p_idx);
      wr.blk_set.en  = go && do_ins;
      wr.blk_set.idx = IDX_W_MAX'(p_idx);
      wr.blk_set.val = IDX_W_MAX'(d);
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go) begin
         rsp_status_ff <= status_c;
         rsp_proc_ff   <= rp_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_proc_ff, rsp_status_ff};

endmodule

FILE: hw/rtl/swqt_cell.sv
// One cell of the table: descriptor INDEX and process INDEX.
// Passes the scan token to its neighbor each cycle. Depends on swqt_pkg.
module swqt_cell #(
   parameter int NUM_PROCS = 32,
   parameter int INDEX     = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                token_in,
   output logic                token_out,
   input  swqt_pkg::query_type query,
   input  swqt_pkg::write_type wr,
   output swqt_pkg::probe_type probe,
   output swqt_pkg::idx_type   next_out,
   output logic                blocked_out,
   output swqt_pkg::idx_type   desc_out
);
   import swqt_pkg::*;

   localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam logic [IW-1:0] MY = IW'(INDEX);

   logic          token_ff;
   logic          valid_ff, valid_in;
   logic [31:0]   key_ff, key_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] next_ff, next_in;
   logic          blocked_ff, blocked_in;
   logic [IW-1:0] desc_ff, desc_in;

   function automatic logic hits(input wport_type w);
      return w.en && (IW'(w.idx) == MY);
   endfunction

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      next_in    = next_ff;
      blocked_in = blocked_ff;
      desc_in    = desc_ff;
      if (wr.rel_en && IW'(wr.rel_idx) == MY) begin
         valid_in = 1'b0;
      end
      if (wr.alloc_en && IW'(wr.alloc_idx) == MY) begin
         valid_in = 1'b1;
         key_in   = wr.alloc_key;
      end
      if (hits(wr.head1)) head_in = IW'(wr.head1.val);
      if (hits(wr.head2)) head_in = IW'(wr.head2.val);
      if (hits(wr.tail1)) tail_in = IW'(wr.tail1.val);
      if (hits(wr.tail2)) tail_in = IW'(wr.tail2.val);
      if (hits(wr.next1)) next_in = IW'(wr.next1.val);
      if (hits(wr.next2)) next_in = IW'(wr.next2.val);
      if (hits(wr.next3)) next_in = IW'(wr.next3.val);
      if (wr.blk_clr_en && IW'(wr.blk_clr_idx) == MY) begin
         blocked_in = 1'b0;
      end
      if (hits(wr.blk_set)) begin
         blocked_in = 1'b1;
         desc_in    = IW'(wr.blk_set.val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff   <= 1'b0;
         valid_ff   <= 1'b0;
         blocked_ff <= 1'b0;
      end else begin
         token_ff   <= token_in;
         valid_ff   <= valid_in;
         blocked_ff <= blocked_in;
      end
      key_ff  <= key_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      next_ff <= next_in;
      desc_ff <= desc_in;
   end

   // Report only while holding the token.
   always_comb begin
      probe       = '0;
      probe.match = token_ff && valid_ff && (key_ff == query.key);
      probe.free  = token_ff && !valid_ff;
      probe.pred  = token_ff && query.pred_en && blocked_ff
                    && (desc_ff == IW'(query.vdesc))
                    && (next_ff == IW'(query.victim))
                    && (MY != IW'(query.victim));
      probe.valid = token_ff && valid_ff;
      if (token_ff) begin
         probe.head = IDX_W_MAX'(head_ff);
         probe.tail = IDX_W_MAX'(tail_ff);
      end
   end

   assign token_out   = token_ff;
   assign next_out    = IDX_W_MAX'(next_ff);
   assign blocked_out = blocked_ff;
   assign desc_out    = IDX_W_MAX'(desc_ff);

endmodule

FILE: test/tb_semaphore_wait_queue_table_top.sv
`timescale 1ns / 100ps
// Testbench for semaphore_wait_queue_table_top: drives insert, remove, take-out and
// peek commands and checks every response against an in-bench table predictor.
// Depends on swqt_pkg and the top-level RTL only.
module tb_semaphore_wait_queue_table_top;
   import swqt_pkg::*;

   localparam int NPROC = 32;
   localparam int LAT = NPROC + 3;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      status_type status;
      logic [4:0] proc;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [39:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   semaphore_wait_queue_table_top #(.NUM_PROCS(NPROC)) dut (.*);

   always #10 clock = ~clock;

   // Predictor state: the semaphore table as the block should hold it.
   bit          slot_used [NPROC];
   logic [31:0] slot_key  [NPROC];
   int          q_first   [NPROC];
   int          q_last    [NPROC];
   int          link_next [NPROC];
   bit          waiting   [NPROC];
   int          owner     [NPROC];

   answer_type  pending_answers[$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_off = 0;
   int          errors = 0;
   longint      cycles = 0;
   logic [31:0] keys[8];

   // Unlink process p from its queue; returns 1 when the queue ran empty.
   function automatic bit unlink(int p);
      int d, cur, nx;
      d = owner[p];
      waiting[p] = 0;
      if (!slot_used[d]) return 0;
      if (q_first[d] == p) begin
         if (q_last[d] == p) return 1;
         q_first[d] = link_next[p];
         return 0;
      end
      cur = q_first[d];
      for (int i = 0; i < NPROC; i++) begin
         nx = link_next[cur];
         if (nx == p) begin
            link_next[cur] = link_next[p];
            if (q_last[d] == p) q_last[d] = cur;
            break;
         end
         if (cur == q_last[d]) break;
         cur = nx;
      end
      return 0;
   endfunction

   function automatic int find_slot(logic [31:0] key);
      for (int i = 0; i < NPROC; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   function automatic answer_type predict_answer(cmd_type cmd, logic [31:0] key, int p);
      answer_type a;
      int d, old;
      bit fresh;
      a.status = STAT_MISS;
      a.proc = '0;
      case (cmd)
         CMD_INSERT: begin
            fresh = 0;
            d = find_slot(key);
            if (d < 0) begin
               for (int i = 0; i < NPROC; i++)
                  if (!slot_used[i]) begin d = i; break; end
               if (d >= 0) begin
                  slot_used[d] = 1;
                  slot_key[d] = key;
                  fresh = 1;
               end
            end
            if (d < 0) a.status = STAT_FULL;
            else begin
               if (waiting[p]) begin
                  old = owner[p];
                  if (unlink(p)) begin
                     if (old == d) fresh = 1;
                     else slot_used[old] = 0;
                  end
               end
               if (fresh) q_first[d] = p;
               else link_next[q_last[d]] = p;
               q_last[d] = p;
               link_next[p] = p;
               owner[p] = d;
               waiting[p] = 1;
               a.status = STAT_OK;
            end
         end
         CMD_REMOVE, CMD_HEAD: begin
            d = find_slot(key);
            if (d >= 0) begin
               a.proc = 5'(q_first[d]);
               a.status = STAT_OK;
               if (cmd == CMD_REMOVE && unlink(q_first[d])) slot_used[d] = 0;
            end
         end
         default: begin
            if (waiting[p]) begin
               old = owner[p];
               if (unlink(p)) slot_used[old] = 0;
               a.proc = 5'(p);
               a.status = STAT_OK;
            end
         end
      endcase
      return a;
   endfunction

   // Offer one beat, wait for acceptance, then record the expected answer.
   // Valid stays up into the next beat unless the sender idles.
   task automatic send_cmd(cmd_type cmd, logic [31:0] key, logic [4:0] p);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {1'b0, p, key, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(predict_answer(cmd, key, int'(p)));
   endtask

   // Randomize the ready line unless a long hold-off is in progress.
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each accepted response beat against the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("response beat with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[6:2] !== want.proc) begin
               $error("result_proc: expected %0d, actual %0d", want.proc, rsp_tdata[6:2]);
               errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] pick_key();
      if ($urandom_range(9) == 0) return $urandom();
      return keys[$urandom_range(7)];
   endfunction

   // Directed: extremes, every command, out-of-queue misses, moves.
   task automatic test_directed();
      send_cmd(CMD_HEAD, 32'h0, 5'd0);
      send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 5'd0);
      send_cmd(CMD_OUT, 32'h0, 5'd31);
      send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd31);
      send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd0);
      send_cmd(CMD_INSERT, 32'h0, 5'd5);
      send_cmd(CMD_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_cmd(CMD_INSERT, 32'h0, 5'd31);          // move to another queue
      send_cmd(CMD_INSERT, 32'h0, 5'd31);          // re-insert on its own queue
      send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd0);   // sole member re-inserted
      send_cmd(CMD_OUT, 32'h0, 5'd5);
      send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 5'd0);
      send_cmd(CMD_REMOVE, 32'h0, 5'd0);
      send_cmd(CMD_HEAD, 32'h0, 5'd0);
   endtask

   // Fill the pool with 32 keys, hit full, then drain it.
   task automatic test_pool_full();
      for (int i = 0; i < NPROC; i++) send_cmd(CMD_INSERT, 32'h1000 + i, i[4:0]);
      send_cmd(CMD_INSERT, 32'hDEAD_BEEF, 5'd3);
      send_cmd(CMD_INSERT, 32'h1000, 5'd7);        // existing key still takes it
      for (int i = 0; i < NPROC; i++) send_cmd(CMD_OUT, 32'h0, i[4:0]);
   endtask

   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 45) send_cmd(CMD_INSERT, pick_key(), 5'($urandom_range(31)));
         else if (r < 65) send_cmd(CMD_REMOVE, pick_key(), 5'($urandom_range(31)));
         else if (r < 80) send_cmd(CMD_OUT, $urandom(), 5'($urandom_range(31)));
         else send_cmd(CMD_HEAD, pick_key(), 5'($urandom_range(31)));
      end
   endtask

   // Hold the receiver off for a long stretch while commands keep coming.
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (6 * LAT) @(posedge clock);
            hold_off = 0;
         end
         test_random(8);
      join
   endtask

   initial begin
      for (int i = 0; i < NPROC; i++) begin
         slot_used[i] = 0; waiting[i] = 0; owner[i] = 0;
         q_first[i] = 0; q_last[i] = 0; link_next[i] = 0;
      end
      keys[0] = 32'h0; keys[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) keys[i] = $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pool_full();
      test_backpressure();
      test_random(180);
      send_idle_pct = 54;
      test_random(180);
      send_idle_pct = 0; recv_stall_pct = 54;
      test_random(180);
      send_idle_pct = 31; recv_stall_pct = 31;
      test_random(150);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (2 * LAT) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
